// ===== hw/rtl/qzcd_pkg.sv =====
// Shared types and constants of the quantized zero-crossing detector.
// Holds the input and result item structs and the crossing and polarity codes.
// Depends on nothing.
`timescale 1ns / 1ps

package qzcd_pkg;

	// Sample width and reset value of the quantization step
	localparam int          SAMPLE_W   = 16;
	localparam int          STEP_W     = 15;
	localparam logic [14:0] STEP_RESET = 15'(3200 / 8);

	// Crossing kinds reported in an item
	localparam logic [1:0] KIND_FIRST = 2'd0;
	localparam logic [1:0] KIND_FALL  = 2'd1;
	localparam logic [1:0] KIND_RISE  = 2'd2;

	// Polarity of the signal once tracking has begun
	typedef enum logic [1:0] {
		POL_NONE = 2'd0,
		POL_POS  = 2'd1,
		POL_NEG  = 2'd2
	} pol_t;

	// One input item
	typedef struct packed {
		logic signed [15:0] sample;
		logic               clear;
	} in_t;

	// One result item
	typedef struct packed {
		logic [1:0]  crossing_kind;
		logic [31:0] segment_index;
		logic [31:0] position_whole;
		logic [15:0] position_frac;
	} out_t;

endpackage

// ===== hw/rtl/quantized_zero_crossing_detector_unit.sv =====
// Top level of the quantized zero-crossing detector: sequencer, detector state
// and result register. Depends on qzcd_pkg and the serial divider qzcd_div.
`timescale 1ns / 1ps

// Usage
// Input channel (in_valid/in_ready/in_data): one signed audio sample per item,
// with a clear flag that restarts the sample index and the detector.
// Output channel (out_valid/out_ready/out_data): at most one crossing report
// per input item, carrying the kind, the index before the crossing and the
// interpolated position (whole part plus FRAC_BITS-bit fraction).
// cfg_we/cfg_wdata write the quantization step; write it only while idle.
// Timing: one serial divider does all the work, one quotient bit per cycle.
// Quantization is a division of the sample magnitude by the step; an item
// without a report then passes the decide step and brings in_ready back. A
// report with a zero endpoint adds the output step. A report whose crossing
// lies between two nonzero samples also adds an interpolating division
// before the output step.
// in_ready is high only while the sequencer is idle.
// A finished report waits in the output register; the next item is accepted
// meanwhile, and only its own report waits for the register to drain.
// Reset clears the detector, the index and the output valid flag and loads
// the step with 400.

module quantized_zero_crossing_detector_unit #(
	parameter int INDEX_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  qzcd_pkg::in_t    in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output qzcd_pkg::out_t   out_data,
	input  logic             cfg_we,
	input  logic [14:0]      cfg_wdata
);

	import qzcd_pkg::*;

	localparam int NUM_W = SAMPLE_W + FRAC_BITS;
	localparam int DEN_W = SAMPLE_W + 1;
	localparam int CNT_W = $clog2(NUM_W + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_QDIV   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_FDIV   = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [STEP_W-1:0]       step_q;
	logic                    neg_q;
	logic [SAMPLE_W-1:0]     prod_q;
	logic signed [15:0]      prev_q;
	logic [INDEX_WIDTH-1:0]  cnt_q;
	pol_t                    pol_q;
	logic                    first_q;
	logic                    started_q;
	logic [1:0]              kind_q;
	logic [INDEX_WIDTH-1:0]  seg_q;
	logic [INDEX_WIDTH-1:0]  whole_q;
	logic [FRAC_BITS-1:0]    frac_q;
	out_t                    out_q;
	logic                    out_valid_q;

	logic                    accept;
	logic [STEP_W-1:0]       step_eff;
	logic signed [16:0]      smp_ext;
	logic [SAMPLE_W-1:0]     smp_mag;
	logic signed [16:0]      y_ext;
	logic signed [15:0]      y;
	logic [SAMPLE_W-1:0]     y_mag;
	logic [SAMPLE_W-1:0]     y0_mag;
	logic                    report;
	logic [1:0]              kind_nx;
	pol_t                    pol_nx;
	logic                    need_div;
	logic                    out_load;

	logic                    div_start;
	logic [NUM_W-1:0]        div_num;
	logic [DEN_W-1:0]        div_den;
	logic [CNT_W-1:0]        div_iters;
	logic                    div_busy;
	logic                    div_done;
	logic [NUM_W-1:0]        div_quot;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// Magnitude of the incoming sample for the quantizing division
	always_comb begin
		smp_ext = 17'(in_data.sample);
		smp_mag = smp_ext[16] ? 16'(-smp_ext) : smp_ext[15:0];
	end

	// Quantized sample with its sign restored, and crossing detection
	always_comb begin
		y_ext    = neg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
		y        = y_ext[15:0];
		y_mag    = y[15] ? 16'(-y_ext) : y_ext[15:0];
		y0_mag   = prev_q[15] ? 16'(-17'(prev_q)) : prev_q;
		report   = 1'b0;
		kind_nx  = KIND_FIRST;
		pol_nx   = pol_q;
		if (started_q) begin
			if (!first_q) begin
				if (prev_q < 0 && y >= 0) begin
					report  = 1'b1;
					kind_nx = KIND_FIRST;
					pol_nx  = POL_POS;
				end
			end else if (pol_q == POL_POS) begin
				if (y < 0) begin
					report  = 1'b1;
					kind_nx = KIND_FALL;
					pol_nx  = POL_NEG;
				end
			end else if (pol_q == POL_NEG) begin
				if (y > 0) begin
					report  = 1'b1;
					kind_nx = KIND_RISE;
					pol_nx  = POL_POS;
				end
			end
		end
		need_div = report && (y != 0) && (prev_q != 0);
	end

	// Divider request: quantization on accept, interpolation from the decide step
	always_comb begin
		div_start = accept || ((state_q == ST_DECIDE) && need_div);
		if (accept) begin
			div_num   = {smp_mag, FRAC_BITS'(0)};
			div_den   = DEN_W'(step_eff);
			div_iters = CNT_W'(SAMPLE_W);
		end else begin
			div_num   = {y0_mag, FRAC_BITS'(0)};
			div_den   = DEN_W'(y0_mag) + DEN_W'(y_mag);
			div_iters = CNT_W'(NUM_W);
		end
	end

	qzcd_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.iters  (div_iters),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Sequencer and detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= STEP_RESET;
			prev_q    <= '0;
			cnt_q     <= '0;
			pol_q     <= POL_NONE;
			first_q   <= 1'b0;
			started_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.clear) begin
							prev_q    <= '0;
							cnt_q     <= '0;
							pol_q     <= POL_NONE;
							first_q   <= 1'b0;
							started_q <= 1'b0;
						end
						state_q <= ST_QDIV;
					end
				end
				ST_QDIV: begin
					if (div_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					prev_q    <= y;
					started_q <= 1'b1;
					cnt_q     <= cnt_q + 1'b1;
					pol_q     <= pol_nx;
					if (report) begin
						first_q <= 1'b1;
						state_q <= need_div ? ST_FDIV : ST_OUT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FDIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload held while the divider runs
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= in_data.sample[15];
		end
		if (state_q == ST_QDIV && div_done) begin
			prod_q <= 16'(div_quot[SAMPLE_W-1:0] * step_eff);
		end
		if (state_q == ST_DECIDE && report) begin
			kind_q  <= kind_nx;
			seg_q   <= cnt_q - 1'b1;
			whole_q <= (y == 0) ? cnt_q : (cnt_q - 1'b1);
			frac_q  <= '0;
		end
		if (state_q == ST_FDIV && div_done) begin
			frac_q <= div_quot[FRAC_BITS-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.crossing_kind  <= kind_q;
			out_q.segment_index  <= 32'(seg_q);
			out_q.position_whole <= 32'(whole_q);
			out_q.position_frac  <= 16'(frac_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The divider is free whenever a new item can be taken
	a_idle_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_busy)
		else $error("divider busy while idle");

	// Divider results only arrive where the sequencer waits for them
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_QDIV || state_q == ST_FDIV))
		else $error("unexpected divider completion");

	// The index advances by exactly one per decided sample
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |=> (cnt_q == INDEX_WIDTH'($past(cnt_q) + 1'b1)))
		else $error("sample index did not advance by one");

	// A new report only appears after the output step of the sequencer
	a_report_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("report loaded outside output step");

endmodule

// ===== hw/rtl/qzcd_div.sv =====
// Bit-serial restoring divider shared by quantization and interpolation.
// One quotient bit per cycle; the numerator is MSB-aligned, iters sets the bit count.
// Depends on nothing.
`timescale 1ns / 1ps

module qzcd_div #(
	parameter int NUM_W = 32,
	parameter int DEN_W = 17
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [NUM_W-1:0]             num,
	input  logic [DEN_W-1:0]             den,
	input  logic [$clog2(NUM_W+1)-1:0]   iters,
	output logic                         busy,
	output logic                         done,
	output logic [NUM_W-1:0]             quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] nq_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] rem_sh;
	logic           ge;
	logic [DEN_W:0] rem_nx;

	// One restoring step: shift in the next numerator bit, subtract if it fits
	always_comb begin
		rem_sh = {rem_q[DEN_W-1:0], nq_q[NUM_W-1]};
		ge     = (rem_sh >= {1'b0, den_q});
		rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	// Control: busy while bits remain, done pulses after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// Datapath: numerator bits leave at the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nq_q  <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			nq_q  <= {nq_q[NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = nq_q;

endmodule

// ===== verif/tb_quantized_zero_crossing_detector_unit.sv =====
// Testbench for the quantized zero-crossing detector: directed and random samples,
// checked against a scoreboard that predicts every crossing report.
// Depends on qzcd_pkg and the top level quantized_zero_crossing_detector_unit.
`timescale 1ns / 1ps

module tb_quantized_zero_crossing_detector_unit;

	import qzcd_pkg::*;

	localparam int FRAC_BITS     = 16;
	localparam int SETTLE_CYCLES = 100;
	localparam int ITEMS_PER_SET = 65;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           in_valid  = 1'b0;
	logic           in_ready;
	in_t            in_data   = '0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	out_t           out_data;
	logic           cfg_we    = 1'b0;
	logic [14:0]    cfg_wdata = '0;

	// Idle rates in percent for the sender and the receiver
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	logic [14:0] step_plan [8];

	// Predicts the crossing reports and holds those not yet seen
	class crossing_scoreboard;
		logic [14:0]        step;
		logic signed [15:0] prev_q;
		logic [31:0]        count;
		pol_t               pol;
		bit                 first_found;
		bit                 started;
		out_t               expected_reports [$];
		int                 mismatches;

		function new();
			step = STEP_RESET;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			prev_q = '0;
			count = '0;
			pol = POL_NONE;
			first_found = 1'b0;
			started = 1'b0;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		// Quantize one accepted sample and queue its report, if any
		function void note_sample(in_t d);
			int                raw;
			int                st;
			int                y;
			int                y0;
			logic [31:0]       i;
			logic [1:0]        kind;
			bit                hit;
			longint unsigned   a;
			longint unsigned   b;
			out_t              r;

			if (d.clear)
				restart();
			raw = $signed(d.sample);
			st = (step == 0) ? 1 : int'(step);
			y = (raw / st) * st;
			i = count;
			y0 = prev_q;
			hit = 1'b0;
			kind = KIND_FIRST;

			if (started) begin
				if (!first_found) begin
					if (y0 < 0 && y >= 0) begin
						hit = 1'b1;
						kind = KIND_FIRST;
						first_found = 1'b1;
						pol = POL_POS;
					end
				end else if (pol == POL_POS) begin
					if (y < 0) begin
						hit = 1'b1;
						kind = KIND_FALL;
						pol = POL_NEG;
					end
				end else if (pol == POL_NEG) begin
					if (y > 0) begin
						hit = 1'b1;
						kind = KIND_RISE;
						pol = POL_POS;
					end
				end
			end

			// Interpolated position: zero endpoints give a whole sample
			if (hit) begin
				r.crossing_kind = kind;
				r.segment_index = i - 32'd1;
				r.position_whole = (y == 0) ? i : i - 32'd1;
				r.position_frac = '0;
				if (y != 0 && y0 != 0) begin
					a = (y0 < 0) ? longint'(-y0) : longint'(y0);
					b = (y < 0) ? longint'(-y) : longint'(y);
					r.position_frac = 16'((a << FRAC_BITS) / (a + b));
				end
				expected_reports.push_back(r);
			end

			prev_q = y[15:0];
			started = 1'b1;
			count = i + 32'd1;
		endfunction

		// Compare one report against the oldest prediction
		function void check_report(out_t got);
			out_t e;

			if (expected_reports.size() == 0) begin
				$display("%0t: unexpected report kind=%0d seg=%0d whole=%0d frac=%0d",
					$time, got.crossing_kind, got.segment_index,
					got.position_whole, got.position_frac);
				mismatches++;
				return;
			end
			e = expected_reports.pop_front();
			if (got.crossing_kind !== e.crossing_kind) begin
				$display("%0t: crossing_kind expected %0d actual %0d",
					$time, e.crossing_kind, got.crossing_kind);
				mismatches++;
			end
			if (got.segment_index !== e.segment_index) begin
				$display("%0t: segment_index expected %0d actual %0d",
					$time, e.segment_index, got.segment_index);
				mismatches++;
			end
			if (got.position_whole !== e.position_whole) begin
				$display("%0t: position_whole expected %0d actual %0d",
					$time, e.position_whole, got.position_whole);
				mismatches++;
			end
			if (got.position_frac !== e.position_frac) begin
				$display("%0t: position_frac expected %0d actual %0d",
					$time, e.position_frac, got.position_frac);
				mismatches++;
			end
		endfunction
	endclass

	crossing_scoreboard sb;

	quantized_zero_crossing_detector_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random stalls on the result channel
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_stall_pct);
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && sb != null && out_valid === 1'b1 && out_ready)
			sb.check_report(out_data);
	end

	// Present one item, with random idle cycles ahead of it
	task automatic send_sample(input logic signed [15:0] s, input bit c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_data = '{sample: s, clear: c};
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		sb.note_sample(in_data);
		@(negedge clk);
	endtask

	// Hold the sender until every predicted report has come out
	task automatic wait_drained();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Step write, only with the block idle
	task automatic write_step(input logic [14:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.step = v;
	endtask

	// Mostly alternating-sign bursts, some raw noise and rare clears
	task automatic run_random(input int n);
		int          sign;
		int          run;
		int          amp;
		int          m;
		logic [15:0] s;
		bit          c;

		sign = 1;
		run = 0;
		amp = 1000;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(39) == 0)
				wait_drained();
			c = ($urandom_range(99) == 0);
			if ($urandom_range(99) < 70) begin
				if (run == 0) begin
					sign = -sign;
					run = $urandom_range(1, 6);
					amp = $urandom_range(1, 32767);
				end
				run--;
				if ($urandom_range(9) == 0)
					m = 0;
				else
					m = $urandom_range(0, amp);
				if (sign < 0 && m == 32767 && $urandom_range(1) == 1)
					m = 32768;
				s = (sign > 0) ? 16'(m) : 16'(-m);
			end else begin
				s = 16'($urandom);
				c = ($urandom_range(49) == 0);
			end
			send_sample(s, c);
		end
	endtask

	// Run time limit
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		sb = new();
		step_plan[0] = 15'($urandom_range(2, 600));
		step_plan[1] = 15'd1;
		step_plan[2] = 15'($urandom_range(600, 8000));
		step_plan[3] = 15'd32767;
		step_plan[4] = 15'd0;
		step_plan[5] = 15'($urandom_range(1, 300));
		step_plan[6] = 15'd16384;
		step_plan[7] = 15'($urandom_range(1, 32767));

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset step: extremes, zero runs and zero endpoints
		send_sample(16'sd0, 1'b1);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd32767, 1'b0);
		send_sample(16'sd399, 1'b0);
		send_sample(-16'sd399, 1'b0);
		send_sample(-16'sd400, 1'b0);
		send_sample(16'sd0, 1'b0);
		send_sample(16'sd1200, 1'b0);
		send_sample(-16'sd800, 1'b0);
		send_sample(16'sd400, 1'b0);
		// Clear mid-stream, then a first crossing that lands on zero
		send_sample(-16'sd32768, 1'b1);
		send_sample(16'sd0, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd32767, 1'b0);

		// Smallest step: samples pass unchanged
		write_step(15'd1);
		send_sample(-16'sd1, 1'b1);
		send_sample(16'sd1, 1'b0);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd32767, 1'b0);

		// Largest step
		write_step(15'd32767);
		send_sample(-16'sd32768, 1'b1);
		send_sample(16'sd32767, 1'b0);
		send_sample(-16'sd32767, 1'b0);

		// Zero step acts as one
		write_step(15'd0);
		send_sample(-16'sd5, 1'b1);
		send_sample(16'sd3, 1'b0);

		// Random part across idle modes and steps
		for (int mode = 0; mode < 4; mode++) begin
			for (int sub = 0; sub < 2; sub++) begin
				write_step(step_plan[mode * 2 + sub]);
				case (mode)
					0: begin
						send_idle_pct = 0;
						recv_stall_pct = 0;
					end
					1: begin
						send_idle_pct = 87;
						recv_stall_pct = 0;
					end
					2: begin
						send_idle_pct = 0;
						recv_stall_pct = 87;
					end
					default: begin
						send_idle_pct = 32;
						recv_stall_pct = 32;
					end
				endcase
				send_sample(16'($urandom), 1'b1);
				run_random(ITEMS_PER_SET);
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
